// ===== rtl/mt19937_random_generator_assert.svh =====
// assertion macros for the random generator
`ifndef MT19937_RANDOM_GENERATOR_ASSERT_SVH
`define MT19937_RANDOM_GENERATOR_ASSERT_SVH

`ifndef NO_ASSERTIONS

// condition holds at every edge outside reset
`define MTRG_ASSERT(name, expr) \
   name: assert property (@(posedge clock) disable iff (reset) (expr)) \
      else $error("mtrg assertion failed");

// trigger implies the condition in the next cycle
`define MTRG_ASSERT_NEXT(name, trig, expr) \
   name: assert property (@(posedge clock) disable iff (reset) (trig) |=> (expr)) \
      else $error("mtrg assertion failed");

`else

`define MTRG_ASSERT(name, expr)
`define MTRG_ASSERT_NEXT(name, trig, expr)

`endif

`endif

// ===== rtl/mtrg_pkg.sv =====
package mtrg_pkg;

   // generator geometry
   localparam int STATE_WORDS_DEF = 624;
   localparam int TAP_OFFSET_DEF  = 397;

   // opcodes
   localparam logic [2:0] OP_RESEED = 3'd0;
   localparam logic [2:0] OP_WORD   = 3'd1;
   localparam logic [2:0] OP_D_1_2  = 3'd2;
   localparam logic [2:0] OP_D_CO   = 3'd3;
   localparam logic [2:0] OP_D_OC   = 3'd4;
   localparam logic [2:0] OP_D_OO   = 3'd5;

   // status codes
   localparam logic ST_OK       = 1'b0;
   localparam logic ST_NOT_SEED = 1'b1;

   // twist and temper constants
   localparam logic [31:0] TWIST_MATRIX = 32'h9908_b0df;
   localparam logic [31:0] SEED_MULT    = 32'd1812433253;
   localparam logic [31:0] TEMPER_B     = 32'h9d2c_5680;
   localparam logic [31:0] TEMPER_C     = 32'hefc6_0000;

   // binary64 layout
   localparam int FRAC_W    = 52;
   localparam int MANT_W    = FRAC_W + 1;
   localparam int EXP_W     = 11;
   localparam int HI_FRAC_W = FRAC_W - 32;
   localparam logic [EXP_W-1:0]  EXP_TOP     = 11'd1023;
   localparam logic [63:0]       ONE_PATTERN = 64'h3FF0_0000_0000_0000;
   localparam logic [MANT_W-1:0] UNIT_K      = {1'b1, {FRAC_W{1'b0}}};

   // normalizer status
   typedef struct packed {
      logic busy;
      logic done;
   } norm_stat_type;

   // output tempering
   function automatic logic [31:0] temper(input logic [31:0] w);
      logic [31:0] y;
      y = w ^ (w >> 11);
      y = y ^ ((y << 7) & TEMPER_B);
      y = y ^ ((y << 15) & TEMPER_C);
      y = y ^ (y >> 18);
      return y;
   endfunction

endpackage

// ===== rtl/mtrg_norm.sv =====
module mtrg_norm
   import mtrg_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   input  logic                start,
   input  logic [MANT_W-1:0]   k,
   output norm_stat_type       stat,
   output logic [63:0]         result
);

   logic                busy_ff, busy_in;
   logic                done_ff, done_in;
   logic                zero_ff, zero_in;
   logic [MANT_W-1:0]   sig_ff, sig_in;
   logic [EXP_W-1:0]    exp_ff, exp_in;

   // one bit of left shift per cycle until the leading one reaches the top
   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      zero_in = zero_ff;
      sig_in  = sig_ff;
      exp_in  = exp_ff;
      if (start) begin
         busy_in = 1'b1;
         zero_in = (k == '0);
         sig_in  = k;
         exp_in  = EXP_TOP;
      end else if (busy_ff) begin
         if (sig_ff[MANT_W-1] || zero_ff) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end else begin
            sig_in = {sig_ff[MANT_W-2:0], 1'b0};
            exp_in = exp_ff - 1'b1;
         end
      end
   end

   // control
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   // datapath
   always_ff @(posedge clock) begin
      zero_ff <= zero_in;
      sig_ff  <= sig_in;
      exp_ff  <= exp_in;
   end

   assign stat.busy = busy_ff;
   assign stat.done = done_ff;
   assign result    = zero_ff ? 64'd0 : {1'b0, exp_ff, sig_ff[FRAC_W-1:0]};

endmodule

// ===== rtl/mt19937_random_generator.sv =====
// MT19937 generator with a 624 x 32 state memory (one write port, two registered
// read ports) under a small sequencer. A reseed beat fills each state word by a
// multiply step followed by an add-and-write step. A word32 draw reads and tempers
// one word; each double draws two words and the [0,1), (0,1] and (0,1) forms add
// a one-bit-per-cycle normalizing shifter, whose run depends on the leading zeros.
// Whenever the 624 words are spent the next draw first runs the twist, one read
// issue and one calc-and-write step per word. A draw before the first reseed
// returns status 1 and value 0. The next beat is accepted as soon as the sequencer
// is idle, even while a result waits on rsp.
`include "mt19937_random_generator_assert.svh"

module mt19937_random_generator
   import mtrg_pkg::*;
#(
   parameter int STATE_WORDS = STATE_WORDS_DEF,
   parameter int TAP_OFFSET  = TAP_OFFSET_DEF
)
(
   input  logic          clock,
   input  logic          reset,
   input  logic          req_valid,
   output logic          req_ready,
   input  logic [2:0]    req_opcode,
   input  logic [31:0]   req_seed,
   output logic          rsp_valid,
   input  logic          rsp_ready,
   output logic [63:0]   rsp_value,
   output logic          rsp_status
);

   localparam int ADDR_W = $clog2(STATE_WORDS);
   localparam int PTR_W  = $clog2(STATE_WORDS + 1);
   localparam logic [ADDR_W-1:0] LAST_IDX = ADDR_W'(STATE_WORDS - 1);

   // sequencer codes
   localparam logic [3:0] S_IDLE     = 4'd0;
   localparam logic [3:0] S_SD_MUL   = 4'd1;
   localparam logic [3:0] S_SD_WR    = 4'd2;
   localparam logic [3:0] S_FETCH    = 4'd3;
   localparam logic [3:0] S_TW_LOAD  = 4'd4;
   localparam logic [3:0] S_TW_CALC  = 4'd5;
   localparam logic [3:0] S_TW_ISSUE = 4'd6;
   localparam logic [3:0] S_TEMPER   = 4'd7;
   localparam logic [3:0] S_NORM     = 4'd8;
   localparam logic [3:0] S_DONE     = 4'd9;

   logic [3:0]          state_ff, state_in;
   logic [PTR_W-1:0]    ptr_ff, ptr_in;
   logic                seeded_ff, seeded_in;
   logic                rsp_valid_ff, rsp_valid_in;
   logic [63:0]         rsp_value_ff, rsp_value_in;
   logic                rsp_status_ff, rsp_status_in;
   logic [2:0]          op_ff, op_in;
   logic                second_ff, second_in;
   logic [31:0]         hi_ff, hi_in;
   logic [31:0]         prev_ff, prev_in;
   logic [31:0]         prod_ff, prod_in;
   logic [31:0]         cur_ff, cur_in;
   logic [ADDR_W-1:0]   idx_ff, idx_in;
   logic [63:0]         res_value_ff, res_value_in;
   logic                res_status_ff, res_status_in;

   // state memory
   logic [31:0]         twist_mem [STATE_WORDS];
   logic [31:0]         rd_a_ff, rd_b_ff;
   logic                mem_we;
   logic [ADDR_W-1:0]   mem_waddr, rd_addr_a, rd_addr_b;
   logic [31:0]         mem_wdata;

   // normalizer
   logic                norm_start;
   logic [MANT_W-1:0]   norm_k;
   norm_stat_type       norm_stat;
   logic [63:0]         norm_result;

   // twist neighbors of the current index
   logic [ADDR_W-1:0]   nxt_idx, tap_idx;
   logic [ADDR_W:0]     tap_sum;
   logic [31:0]         twist_y, twist_v, seed_word, tempered;
   logic [FRAC_W-1:0]   frac;

   always_comb begin
      nxt_idx = (idx_ff == LAST_IDX) ? '0 : idx_ff + 1'b1;
      tap_sum = {1'b0, idx_ff} + (ADDR_W + 1)'(TAP_OFFSET);
      tap_idx = (tap_sum >= (ADDR_W + 1)'(STATE_WORDS)) ?
                ADDR_W'(tap_sum - (ADDR_W + 1)'(STATE_WORDS)) : tap_sum[ADDR_W-1:0];
      twist_y = {cur_ff[31], rd_a_ff[30:0]};
      twist_v = rd_b_ff ^ (twist_y >> 1) ^ (twist_y[0] ? TWIST_MATRIX : 32'd0);
      seed_word = prod_ff + {{(32 - ADDR_W){1'b0}}, idx_ff};
      tempered  = temper(rd_a_ff);
      frac      = {hi_ff[HI_FRAC_W-1:0], tempered};
   end

   assign req_ready = (state_ff == S_IDLE);

   // sequencer
   always_comb begin
      state_in      = state_ff;
      ptr_in        = ptr_ff;
      seeded_in     = seeded_ff;
      rsp_valid_in  = rsp_valid_ff;
      rsp_value_in  = rsp_value_ff;
      rsp_status_in = rsp_status_ff;
      op_in         = op_ff;
      second_in     = second_ff;
      hi_in         = hi_ff;
      prev_in       = prev_ff;
      prod_in       = prod_ff;
      cur_in        = cur_ff;
      idx_in        = idx_ff;
      res_value_in  = res_value_ff;
      res_status_in = res_status_ff;
      mem_we        = 1'b0;
      mem_waddr     = '0;
      mem_wdata     = '0;
      rd_addr_a     = '0;
      rd_addr_b     = '0;
      norm_start    = 1'b0;
      norm_k        = '0;

      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end

      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               op_in         = req_opcode;
               second_in     = 1'b0;
               res_value_in  = 64'd0;
               res_status_in = ST_OK;
               priority if (req_opcode == OP_RESEED) begin
                  mem_we    = 1'b1;
                  mem_waddr = '0;
                  mem_wdata = req_seed;
                  prev_in   = req_seed;
                  idx_in    = ADDR_W'(1);
                  state_in  = S_SD_MUL;
               end else if (req_opcode > OP_D_OO) begin
                  state_in = S_DONE;
               end else if (!seeded_ff) begin
                  res_status_in = ST_NOT_SEED;
                  state_in      = S_DONE;
               end else begin
                  state_in = S_FETCH;
               end
            end
         end
         // seed recurrence: multiply, then add index and write
         S_SD_MUL: begin
            prod_in  = SEED_MULT * (prev_ff ^ (prev_ff >> 30));
            state_in = S_SD_WR;
         end
         S_SD_WR: begin
            mem_we    = 1'b1;
            mem_waddr = idx_ff;
            mem_wdata = seed_word;
            prev_in   = seed_word;
            if (idx_ff == LAST_IDX) begin
               ptr_in    = PTR_W'(STATE_WORDS);
               seeded_in = 1'b1;
               state_in  = S_DONE;
            end else begin
               idx_in   = idx_ff + 1'b1;
               state_in = S_SD_MUL;
            end
         end
         // read next word, or start a twist when spent
         S_FETCH: begin
            if (ptr_ff >= PTR_W'(STATE_WORDS)) begin
               idx_in    = '0;
               rd_addr_a = '0;
               state_in  = S_TW_LOAD;
            end else begin
               rd_addr_a = ptr_ff[ADDR_W-1:0];
               ptr_in    = ptr_ff + 1'b1;
               state_in  = S_TEMPER;
            end
         end
         S_TW_LOAD: begin
            cur_in    = rd_a_ff;
            rd_addr_a = nxt_idx;
            rd_addr_b = tap_idx;
            state_in  = S_TW_CALC;
         end
         S_TW_CALC: begin
            mem_we    = 1'b1;
            mem_waddr = idx_ff;
            mem_wdata = twist_v;
            cur_in    = rd_a_ff;
            if (idx_ff == LAST_IDX) begin
               ptr_in   = '0;
               state_in = S_FETCH;
            end else begin
               idx_in   = idx_ff + 1'b1;
               state_in = S_TW_ISSUE;
            end
         end
         S_TW_ISSUE: begin
            rd_addr_a = nxt_idx;
            rd_addr_b = tap_idx;
            state_in  = S_TW_CALC;
         end
         // temper and assemble the result
         S_TEMPER: begin
            if (op_ff == OP_WORD) begin
               res_value_in = {32'd0, tempered};
               state_in     = S_DONE;
            end else if (!second_ff) begin
               hi_in     = tempered;
               second_in = 1'b1;
               state_in  = S_FETCH;
            end else begin
               unique case (op_ff)
                  OP_D_1_2: begin
                     res_value_in = ONE_PATTERN | {{(64 - FRAC_W){1'b0}}, frac};
                  end
                  OP_D_CO: begin
                     norm_k = {1'b0, frac};
                  end
                  OP_D_OC: begin
                     norm_k = UNIT_K - {1'b0, frac};
                  end
                  default: begin
                     norm_k = {1'b0, frac[FRAC_W-1:1], 1'b1};
                  end
               endcase
               if (op_ff == OP_D_1_2) begin
                  state_in = S_DONE;
               end else begin
                  norm_start = 1'b1;
                  state_in   = S_NORM;
               end
            end
         end
         S_NORM: begin
            if (norm_stat.done) begin
               res_value_in = norm_result;
               state_in     = S_DONE;
            end
         end
         // move result into the output register once it is free
         S_DONE: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in  = 1'b1;
               rsp_value_in  = res_value_ff;
               rsp_status_in = res_status_ff;
               state_in      = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         ptr_ff       <= PTR_W'(STATE_WORDS);
         seeded_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         ptr_ff       <= ptr_in;
         seeded_ff    <= seeded_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      rsp_value_ff  <= rsp_value_in;
      rsp_status_ff <= rsp_status_in;
      op_ff         <= op_in;
      second_ff     <= second_in;
      hi_ff         <= hi_in;
      prev_ff       <= prev_in;
      prod_ff       <= prod_in;
      cur_ff        <= cur_in;
      idx_ff        <= idx_in;
      res_value_ff  <= res_value_in;
      res_status_ff <= res_status_in;
   end

   // state memory, one write and two registered reads
   always_ff @(posedge clock) begin
      if (mem_we) begin
         twist_mem[mem_waddr] <= mem_wdata;
      end
      rd_a_ff <= twist_mem[rd_addr_a];
      rd_b_ff <= twist_mem[rd_addr_b];
   end

   mtrg_norm u_norm (
      .clock  (clock),
      .reset  (reset),
      .start  (norm_start),
      .k      (norm_k),
      .stat   (norm_stat),
      .result (norm_result)
   );

   assign rsp_valid  = rsp_valid_ff;
   assign rsp_value  = rsp_value_ff;
   assign rsp_status = rsp_status_ff;

   // checks
   `MTRG_ASSERT(a_ptr_range, ptr_ff <= PTR_W'(STATE_WORDS))
   `MTRG_ASSERT(a_twist_seeded, (state_ff == S_TW_LOAD || state_ff == S_TW_CALC || state_ff == S_TW_ISSUE) |-> seeded_ff)
   `MTRG_ASSERT(a_norm_owned, (norm_stat.busy || norm_stat.done) |-> state_ff == S_NORM)
   `MTRG_ASSERT_NEXT(a_rsp_load, state_ff == S_DONE && (!rsp_valid_ff || rsp_ready), rsp_valid_ff && state_ff == S_IDLE)

endmodule

// ===== test/mt19937_random_generator_tb.sv =====
`timescale 1ns / 1ps

module mt19937_random_generator_tb;
   import mtrg_pkg::*;

   // opcodes the block ignores
   localparam logic [2:0] OP_SPARE_6 = 3'd6;
   localparam logic [2:0] OP_SPARE_7 = 3'd7;

   localparam int CYCLE_LIMIT = 1_000_000;
   localparam int DRAIN_LIMIT = 20_000;
   localparam int TAIL_CYCLES = 100;
   localparam int HOLD_CYCLES = 400;
   localparam int RANDOM_ITEMS = 1050;

   typedef struct packed {
      logic [63:0] value;
      logic        status;
   } result_beat_type;

   typedef enum int {RX_OPEN, RX_RANDOM, RX_SPARSE} rx_mode_type;

   logic        clock;
   logic        reset;
   logic        req_valid;
   logic        req_ready;
   logic [2:0]  req_opcode;
   logic [31:0] req_seed;
   logic        rsp_valid;
   logic        rsp_ready;
   logic [63:0] rsp_value;
   logic        rsp_status;

   mt19937_random_generator DUT (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_ready  (req_ready),
      .req_opcode (req_opcode),
      .req_seed   (req_seed),
      .rsp_valid  (rsp_valid),
      .rsp_ready  (rsp_ready),
      .rsp_value  (rsp_value),
      .rsp_status (rsp_status)
   );

   // generator shadow state
   logic [31:0]  gen_words [0:STATE_WORDS_DEF-1];
   int unsigned  gen_ptr;
   bit           gen_seeded;

   result_beat_type expected_results [$];
   result_beat_type want;

   int fail_count;
   int checked_beats;
   int n_reseed, n_word, n_double, n_unseeded, n_spare, n_long_holds;
   int burst_left;
   bit paced;
   bit hold_rsp;
   int cycle_count;

   // clock
   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   // knuth multiplier fill from a seed; leaves the state spent
   function automatic void seed_words(input logic [31:0] s);
      gen_words[0] = s;
      for (int i = 1; i < STATE_WORDS_DEF; i++)
         gen_words[i] = SEED_MULT * (gen_words[i-1] ^ (gen_words[i-1] >> 30)) + 32'(i);
      gen_ptr    = STATE_WORDS_DEF;
      gen_seeded = 1'b1;
   endfunction

   // full twist over all words
   function automatic void regenerate_words();
      logic [31:0] y;
      logic [31:0] v;
      for (int i = 0; i < STATE_WORDS_DEF; i++) begin
         y = (gen_words[i] & 32'h8000_0000)
           | (gen_words[(i + 1) % STATE_WORDS_DEF] & 32'h7fff_ffff);
         v = gen_words[(i + TAP_OFFSET_DEF) % STATE_WORDS_DEF] ^ (y >> 1);
         if (y[0]) v = v ^ TWIST_MATRIX;
         gen_words[i] = v;
      end
      gen_ptr = 0;
   endfunction

   function automatic logic [31:0] tempered(input logic [31:0] w);
      logic [31:0] t;
      t = w;
      t = t ^ {11'd0, t[31:11]};
      t = t ^ ({t[24:0], 7'd0} & TEMPER_B);
      t = t ^ ({t[16:0], 15'd0} & TEMPER_C);
      t = t ^ {18'd0, t[31:18]};
      return t;
   endfunction

   // next tempered word, twisting first when spent
   function automatic logic [31:0] next_word();
      logic [31:0] w;
      if (gen_ptr >= STATE_WORDS_DEF) regenerate_words();
      w = gen_words[gen_ptr];
      gen_ptr++;
      return tempered(w);
   endfunction

   // exact binary64 pattern of k * 2^-52
   function automatic logic [63:0] exact_double(input logic [52:0] k);
      int          lead;
      logic [52:0] norm;
      logic [10:0] expo;
      if (k == '0) return 64'd0;
      lead = 0;
      for (int b = 0; b < MANT_W; b++)
         if (k[b]) lead = b;
      norm = k << (FRAC_W - lead);
      expo = 11'(1023 + lead - FRAC_W);
      return {1'b0, expo, norm[51:0]};
   endfunction

   function automatic logic [63:0] draw_value(input logic [2:0] op);
      logic [31:0] hi;
      logic [31:0] lo;
      logic [51:0] m;
      if (op == OP_WORD) return {32'd0, next_word()};
      hi = next_word();
      lo = next_word();
      m  = {hi[19:0], lo};
      case (op)
         OP_D_1_2: return ONE_PATTERN | {12'd0, m};
         OP_D_CO:  return exact_double({1'b0, m});
         OP_D_OC:  return exact_double(UNIT_K - {1'b0, m});
         default:  return exact_double({1'b0, m[51:1], 1'b1});
      endcase
   endfunction

   // expected result of one accepted beat
   function automatic void predict_result(input logic [2:0] op, input logic [31:0] s);
      result_beat_type r;
      r.value  = 64'd0;
      r.status = ST_OK;
      if (op == OP_RESEED) begin
         seed_words(s);
         n_reseed++;
      end else if (op <= OP_D_OO) begin
         if (!gen_seeded) begin
            r.status = ST_NOT_SEED;
            n_unseeded++;
         end else begin
            r.value = draw_value(op);
            if (op == OP_WORD) n_word++;
            else n_double++;
         end
      end else begin
         n_spare++;
      end
      expected_results.push_back(r);
   endfunction

   // one request beat, with optional burst pacing
   task automatic send_beat(input logic [2:0] op, input logic [31:0] s);
      if (paced && burst_left == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 8)) @(posedge clock);
         burst_left = $urandom_range(1, 24);
      end
      if (burst_left > 0) burst_left--;
      req_valid  <= 1'b1;
      req_opcode <= op;
      req_seed   <= s;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      predict_result(op, s);
   endtask

   // wait for all outstanding results
   task automatic drain_results();
      int waited;
      waited = 0;
      req_valid <= 1'b0;
      while (expected_results.size() != 0 && waited < DRAIN_LIMIT) begin
         @(posedge clock);
         waited++;
      end
   endtask

   function automatic logic [2:0] any_double();
      return OP_D_1_2 + 3'($urandom_range(0, 3));
   endfunction

   // draws and spare opcodes before any seed
   task automatic test_unseeded();
      send_beat(OP_WORD, $urandom);
      send_beat(OP_D_1_2, $urandom);
      send_beat(OP_D_CO, $urandom);
      send_beat(OP_D_OC, $urandom);
      send_beat(OP_D_OO, $urandom);
      send_beat(OP_SPARE_6, $urandom);
      send_beat(OP_SPARE_7, $urandom);
      drain_results();
   endtask

   // extreme seeds, every draw form, back-to-back reseeds
   task automatic test_seed_extremes();
      send_beat(OP_RESEED, 32'd0);
      send_beat(OP_WORD, 32'd0);
      send_beat(OP_D_1_2, 32'd0);
      send_beat(OP_D_CO, 32'd0);
      send_beat(OP_D_OC, 32'd0);
      send_beat(OP_D_OO, 32'd0);
      send_beat(OP_RESEED, 32'd5489);
      send_beat(OP_RESEED, 32'hffff_ffff);
      send_beat(OP_D_OO, 32'hffff_ffff);
      send_beat(OP_D_OC, 32'hffff_ffff);
      send_beat(OP_D_CO, 32'hffff_ffff);
      send_beat(OP_D_1_2, 32'hffff_ffff);
      send_beat(OP_WORD, 32'hffff_ffff);
      send_beat(OP_SPARE_6, 32'hffff_ffff);
      send_beat(OP_SPARE_7, 32'd0);
      send_beat(OP_RESEED, 32'd5489);
      send_beat(OP_WORD, 32'd0);
      drain_results();
   endtask

   // a double whose two words straddle the twist
   task automatic test_straddled_double();
      paced = 1'b1;
      send_beat(OP_RESEED, $urandom);
      send_beat(OP_WORD, $urandom);
      repeat (STATE_WORDS_DEF / 2) send_beat(any_double(), $urandom);
      send_beat(OP_WORD, $urandom);
      drain_results();
      paced = 1'b0;
   endtask

   // receiver holds off while draws keep coming
   task automatic test_backpressure();
      send_beat(OP_RESEED, $urandom);
      send_beat(OP_WORD, $urandom);
      drain_results();
      hold_rsp = 1'b1;
      repeat (6) send_beat(OP_WORD, $urandom);
      repeat (6) send_beat(any_double(), $urandom);
      drain_results();
   endtask

   // random mix of reseeds, draws and spare opcodes
   task automatic test_random_mix();
      int          pick;
      logic [31:0] s;
      paced = 1'b1;
      for (int n = 0; n < RANDOM_ITEMS; n++) begin
         pick = $urandom_range(0, 99);
         case ($urandom_range(0, 7))
            0:       s = 32'($urandom_range(0, 15));
            1:       s = 32'hffff_ffff - 32'($urandom_range(0, 15));
            default: s = $urandom;
         endcase
         if (pick < 2) send_beat(OP_RESEED, s);
         else if (pick < 4) send_beat(3'($urandom_range(6, 7)), s);
         else if (pick < 45) send_beat(OP_WORD, s);
         else send_beat(any_double(), s);
      end
      paced = 1'b0;
      drain_results();
   endtask

   // receiver: changing stall patterns plus one long hold
   initial begin : rsp_side
      rx_mode_type mode;
      int          mode_left;
      int          held;
      int          tick;
      mode      = RX_OPEN;
      mode_left = 0;
      tick      = 0;
      rsp_ready <= 1'b0;
      forever begin
         @(posedge clock);
         tick++;
         if (hold_rsp) begin
            rsp_ready <= 1'b0;
            held = 0;
            while (held < HOLD_CYCLES) begin
               @(posedge clock);
               held++;
            end
            hold_rsp = 1'b0;
            n_long_holds++;
         end else begin
            if (mode_left == 0) begin
               mode      = rx_mode_type'($urandom_range(0, 2));
               mode_left = $urandom_range(16, 160);
            end
            mode_left--;
            case (mode)
               RX_OPEN:   rsp_ready <= 1'b1;
               RX_RANDOM: rsp_ready <= 1'($urandom_range(0, 1));
               default:   rsp_ready <= (tick % 6 == 0);
            endcase
         end
      end
   end

   // compare each result beat with the oldest expectation
   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) begin
         if (expected_results.size() == 0) begin
            $error("unexpected result beat: value %h status %0d", rsp_value, rsp_status);
            fail_count++;
         end else begin
            want = expected_results.pop_front();
            checked_beats++;
            if (rsp_value !== want.value) begin
               $error("value mismatch: expected %h, actual %h", want.value, rsp_value);
               fail_count++;
            end
            if (rsp_status !== want.status) begin
               $error("status mismatch: expected %0d, actual %0d", want.status, rsp_status);
               fail_count++;
            end
         end
      end
   end

   // watchdog
   initial begin
      cycle_count = 0;
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("mt19937_random_generator test failed");
      $finish;
   end

   initial begin
      fail_count    = 0;
      checked_beats = 0;
      n_reseed      = 0;
      n_word        = 0;
      n_double      = 0;
      n_unseeded    = 0;
      n_spare       = 0;
      n_long_holds  = 0;
      burst_left    = 0;
      paced         = 1'b0;
      hold_rsp      = 1'b0;
      gen_ptr       = STATE_WORDS_DEF;
      gen_seeded    = 1'b0;
      reset      <= 1'b1;
      req_valid  <= 1'b0;
      req_opcode <= OP_RESEED;
      req_seed   <= 32'd0;
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      test_unseeded();
      test_seed_extremes();
      test_backpressure();
      test_straddled_double();
      test_random_mix();

      // settle, then look for stray or missing results
      drain_results();
      repeat (TAIL_CYCLES) @(posedge clock);
      if (expected_results.size() != 0) begin
         $error("%0d expected results never arrived", expected_results.size());
         fail_count++;
      end

      $display("covered %0d reseeds, %0d word draws, %0d double draws, %0d unseeded draws",
               n_reseed, n_word, n_double, n_unseeded);
      $display("plus %0d spare opcodes and %0d long receiver holds; %0d beats checked",
               n_spare, n_long_holds, checked_beats);
      if (fail_count == 0) begin
         $display("mt19937_random_generator test passed");
      end else begin
         $display("mt19937_random_generator test failed");
      end
      $finish;
   end

endmodule
